### rtl/linear_probe_hash_map_macros.svh
// Assertion macros used by the hash map back stage.
// Depends on: clk_i and rst_ni in the module that includes it.
`ifndef LINEAR_PROBE_HASH_MAP_MACROS_SVH
`define LINEAR_PROBE_HASH_MAP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LPHM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define LPHM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lphm_pkg.sv
// Types and constants of the hash map.
// No dependencies.
package lphm_pkg;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_e;

endpackage

### rtl/linear_probe_hash_map.sv
// Top level of the linear probing hash map: front, request queue, back, result queue.
// Depends on lphm_pkg, lphm_front, lphm_fifo, lphm_back.
//
//  Channel  | Handshake      | Fields
//  ---------+----------------+--------------------------------------------
//  request  | push / full    | kind_i, key_i, value_in_i
//  result   | pop / empty    | status_o, found_o, value_out_o, live_entries_o
//
// A request is hashed in the front, leaves the request queue, runs the probe
// loop (one slot read per cycle), then is updated and emitted; a no-op skips
// the probe. After reset the slot marks are swept to empty before the first
// request runs; requests are queued meanwhile. A stalled result side holds
// the back stage once the two-entry result queue fills.
module linear_probe_hash_map
  import lphm_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  kind_i,
  input  logic signed [31:0]          key_i,
  input  logic [31:0]                 value_in_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  status_o,
  output logic                        found_o,
  output logic [31:0]                 value_out_o,
  output logic [$clog2(CAPACITY):0]   live_entries_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned LW = IW + 1;
  // Stored values are masked to VALUE_BITS; inputs carry only 32 bits.
  localparam int unsigned VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int unsigned QW = 2 + 32 + VW + IW;
  localparam int unsigned RW = 2 + 1 + 32 + LW;

  logic          fq_push, fq_full, fq_pop, fq_empty;
  logic [1:0]    f_kind, b_kind;
  logic [31:0]   f_key, b_key;
  logic [VW-1:0] f_val, b_val;
  logic [IW-1:0] f_home, b_home;
  logic [QW-1:0] fq_rdata;

  logic          rq_push, rq_full;
  logic [1:0]    r_status;
  logic          r_found;
  logic [31:0]   r_value;
  logic [LW-1:0] r_live;

  lphm_front #(.CAPACITY(CAPACITY), .VW(VW)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .kind_i, .key_i, .value_in_i,
    .q_push_o(fq_push), .q_full_i(fq_full),
    .kind_o(f_kind), .key_o(f_key), .val_o(f_val), .home_o(f_home)
  );

  // Hold classified requests so the front keeps accepting while the back probes.
  lphm_fifo #(.WIDTH(QW), .DEPTH(2)) u_req_q (
    .clk_i, .rst_ni,
    .push_i(fq_push), .wdata_i({f_kind, f_key, f_val, f_home}), .full_o(fq_full),
    .pop_i(fq_pop), .rdata_o(fq_rdata), .empty_o(fq_empty)
  );

  assign {b_kind, b_key, b_val, b_home} = fq_rdata;

  lphm_back #(.CAPACITY(CAPACITY), .VW(VW)) u_back (
    .clk_i, .rst_ni,
    .q_empty_i(fq_empty), .q_pop_o(fq_pop),
    .kind_i(b_kind), .key_i(b_key), .val_i(b_val), .home_i(b_home),
    .out_full_i(rq_full), .out_push_o(rq_push),
    .status_o(r_status), .found_o(r_found), .value_o(r_value), .live_o(r_live)
  );

  // Result queue: finished results wait here while the back takes the next request.
  lphm_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
    .clk_i, .rst_ni,
    .push_i(rq_push), .wdata_i({r_status, r_found, r_value, r_live}), .full_o(rq_full),
    .pop_i(pop), .rdata_o({status_o, found_o, value_out_o, live_entries_o}),
    .empty_o(empty)
  );

endmodule

### rtl/lphm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lphm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/lphm_fifo.sv
// Small register FIFO used between the hash map stages.
// No dependencies.
module lphm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW + 1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

### rtl/lphm_front.sv
// Front stage: accept requests, hash the key to its home slot.
// Depends on lphm_pkg.
module lphm_front
  import lphm_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned VW       = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [1:0]                  kind_i,
  input  logic signed [31:0]          key_i,
  input  logic [31:0]                 value_in_i,
  output logic                        q_push_o,
  input  logic                        q_full_i,
  output logic [1:0]                  kind_o,
  output logic [31:0]                 key_o,
  output logic [VW-1:0]               val_o,
  output logic [$clog2(CAPACITY)-1:0] home_o
);

  localparam int unsigned IW = $clog2(CAPACITY);

  logic            v_q;
  logic [1:0]      kind_q;
  logic [31:0]     key_q;
  logic [VW-1:0]   val_q;
  logic [IW-1:0]   home_q;
  logic [2*IW-1:0] prod;
  logic            accept;

  // Only the low index bits of the 32-bit product are needed.
  assign prod   = key_i[IW-1:0] * HASH_MULT[IW-1:0];
  assign full_o = v_q && q_full_i;
  assign accept = push_i && !full_o;

  assign q_push_o = v_q;
  assign kind_o   = kind_q;
  assign key_o    = key_q;
  assign val_o    = val_q;
  assign home_o   = home_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      kind_q <= '0;
      key_q  <= '0;
      val_q  <= '0;
      home_q <= '0;
    end else if (accept) begin
      v_q    <= 1'b1;
      kind_q <= kind_i;
      key_q  <= key_i;
      val_q  <= value_in_i[VW-1:0];
      home_q <= prod[IW-1:0];
    end else if (!q_full_i) begin
      v_q <= 1'b0;
    end
  end

endmodule

### rtl/lphm_back.sv
// Back stage: probe engine over the slot stores, updates and results.
// Depends on lphm_pkg, lphm_ram and the assertion macro header.
`include "linear_probe_hash_map_macros.svh"

module lphm_back
  import lphm_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned VW       = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  input  logic [1:0]                  kind_i,
  input  logic [31:0]                 key_i,
  input  logic [VW-1:0]               val_i,
  input  logic [$clog2(CAPACITY)-1:0] home_i,
  input  logic                        out_full_i,
  output logic                        out_push_o,
  output logic [1:0]                  status_o,
  output logic                        found_o,
  output logic [31:0]                 value_o,
  output logic [$clog2(CAPACITY):0]   live_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned LW = IW + 1;
  localparam logic [LW-1:0] CAP_N     = LW'(CAPACITY);
  localparam logic [LW-1:0] OCC_LIMIT = LW'(CAPACITY * 3 / 4);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_ACT} state_e;

  state_e        state_q;
  kind_e         kind_q;
  logic          kind_ok_q;
  logic [31:0]   key_q;
  logic [VW-1:0] val_q, hval_q;
  logic [IW-1:0] addr_q, didx_q, ins_q, hit_q, clr_q;
  logic [LW-1:0] n_q, occ_q, live_q, live_next, occ_next;
  logic          pend_q, tomb_q, ins_empty_q, found_q;

  logic [1:0]    mark_rd, mark_wdata;
  logic [31:0]   key_rd;
  logic [VW-1:0] val_rd;
  logic          clearing, act, put_new, rem_hit;
  logic          mark_we, key_we, val_we;
  logic [IW-1:0] mark_waddr, val_waddr;

  lphm_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_marks (
    .clk_i, .we_i(mark_we), .waddr_i(mark_waddr), .wdata_i(mark_wdata),
    .raddr_i(addr_q), .rdata_o(mark_rd)
  );
  lphm_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_keys (
    .clk_i, .we_i(key_we), .waddr_i(ins_q), .wdata_i(key_q),
    .raddr_i(addr_q), .rdata_o(key_rd)
  );
  lphm_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_vals (
    .clk_i, .we_i(val_we), .waddr_i(val_waddr), .wdata_i(val_q),
    .raddr_i(addr_q), .rdata_o(val_rd)
  );

  assign clearing = (state_q == S_CLEAR);
  assign act      = (state_q == S_ACT) && !out_full_i;
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;
  assign put_new  = kind_ok_q && kind_q == KIND_PUT && !found_q && occ_q < OCC_LIMIT;
  assign rem_hit  = kind_ok_q && kind_q == KIND_REMOVE && found_q;

  always_comb begin
    mark_we    = clearing || (act && (put_new || rem_hit));
    mark_waddr = clearing ? clr_q : (put_new ? ins_q : hit_q);
    mark_wdata = clearing ? MARK_EMPTY : (put_new ? MARK_LIVE : MARK_TOMB);
    key_we     = act && put_new;
    val_we     = act && (put_new || (kind_ok_q && kind_q == KIND_PUT && found_q));
    val_waddr  = found_q ? hit_q : ins_q;
    live_next  = live_q + LW'(put_new) - LW'(rem_hit);
    occ_next   = occ_q + LW'(put_new && ins_empty_q);
  end

  always_comb begin
    status_o = STATUS_DONE;
    value_o  = '0;
    if (kind_ok_q) begin
      case (kind_q)
        KIND_PUT: begin
          if (!found_q && !put_new) status_o = STATUS_FULL;
        end
        KIND_GET: begin
          if (found_q) value_o = 32'(hval_q);
          else status_o = STATUS_NOT_FOUND;
        end
        KIND_REMOVE: begin
          if (!found_q) status_o = STATUS_NOT_FOUND;
        end
        default: status_o = STATUS_DONE;
      endcase
    end
  end

  assign out_push_o = act;
  assign found_o    = found_q;
  assign live_o     = live_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      occ_q       <= '0;
      live_q      <= '0;
      kind_q      <= KIND_PUT;
      kind_ok_q   <= 1'b0;
      key_q       <= '0;
      val_q       <= '0;
      hval_q      <= '0;
      addr_q      <= '0;
      didx_q      <= '0;
      ins_q       <= '0;
      hit_q       <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      tomb_q      <= 1'b0;
      ins_empty_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty_i) begin
            kind_q      <= kind_e'(kind_i);
            kind_ok_q   <= (kind_i inside {KIND_PUT, KIND_GET, KIND_REMOVE});
            key_q       <= key_i;
            val_q       <= val_i;
            addr_q      <= home_i;
            n_q         <= '0;
            pend_q      <= 1'b0;
            tomb_q      <= 1'b0;
            ins_empty_q <= 1'b0;
            found_q     <= 1'b0;
            state_q     <= (kind_i inside {KIND_PUT, KIND_GET, KIND_REMOVE}) ? S_LOOK : S_ACT;
          end
        end
        S_LOOK: begin
          // Issue the next read every cycle; the read data follows in the next cycle.
          addr_q <= addr_q + 1'b1;
          didx_q <= addr_q;
          pend_q <= 1'b1;
          if (pend_q) begin
            if (n_q == CAP_N) begin
              state_q <= S_ACT;
            end else begin
              n_q <= n_q + 1'b1;
              if (mark_rd == MARK_EMPTY) begin
                if (!tomb_q) begin
                  ins_q       <= didx_q;
                  ins_empty_q <= 1'b1;
                end
                state_q <= S_ACT;
              end else if (mark_rd == MARK_LIVE && key_rd == key_q) begin
                found_q <= 1'b1;
                hit_q   <= didx_q;
                hval_q  <= val_rd;
                state_q <= S_ACT;
              end else if (mark_rd == MARK_TOMB && !tomb_q) begin
                tomb_q <= 1'b1;
                ins_q  <= didx_q;
              end
            end
          end
        end
        S_ACT: begin
          if (!out_full_i) begin
            occ_q   <= occ_next;
            live_q  <= live_next;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `LPHM_ASSERT(a_live_le_occ, live_q <= occ_q, "live count above occupied count")
  `LPHM_ASSERT(a_occ_bound, occ_q <= OCC_LIMIT, "occupied count above fill limit")
  `LPHM_ASSERT(a_probe_bound, n_q <= CAP_N, "probe ran past table size")
  `LPHM_ASSERT_NEXT(a_act_done, act, state_q == S_IDLE, "result issued without return to idle")

endmodule
